[rtl/echo_range_moving_average_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the echo range moving average core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ECHO_RANGE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define ECHO_RANGE_MOVING_AVERAGE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge out of reset.
`define ERMA_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("erma assertion failed");

// Checks that a consequence holds in the same cycle as its antecedent.
`define ERMA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("erma implication failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define ERMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("erma next-cycle check failed");

`else

`define ERMA_ASSERT(lbl, cond)
`define ERMA_ASSERT_IMPL(lbl, ante, cons)
`define ERMA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/erma_pkg.sv]
// ----------------------------------------------------------------------------
// erma_pkg
// Types and constants shared by the echo range moving average core.
// ----------------------------------------------------------------------------
package erma_pkg;

	// Sizing of the averaging bank.
	localparam int SENSORS = 4;
	localparam int TAPS    = 4;

	// Field widths.
	localparam int ECHO_W   = 16;
	localparam int SENSOR_W = 2;
	localparam int CM_W     = 11;

	// Index widths derived from the sizing.
	localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int TAP_W  = $clog2(TAPS);
	localparam int SUM_W  = CM_W + TAP_W;

	// Microseconds to centimeters: truncating divide by 58, done as a
	// multiply by a rounded-up reciprocal and a right shift. The rounding
	// error times the largest echo stays below one unit of the shifted scale.
	localparam int CM_DIVISOR = 58;
	localparam int CM_SHIFT   = 22;
	localparam int CM_RECIP   = ((2 ** CM_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
	localparam int RECIP_W    = $clog2(CM_RECIP + 1);
	localparam int PROD_W     = ECHO_W + RECIP_W;
	localparam int CM_MAX     = ((2 ** ECHO_W) - 1) / CM_DIVISOR;

	localparam logic [CM_W-1:0] THRESHOLD_RESET = CM_W'(30);

	typedef struct packed {
		logic [ECHO_W-1:0]   echo_us;
		logic [SENSOR_W-1:0] sensor_index;
	} in_item_t;

	typedef struct packed {
		logic [SENSOR_W-1:0] sensor_out;
		logic [CM_W-1:0]     average_cm;
		logic                near_first;
		logic                near_second;
	} out_item_t;

	// Update request from the conversion stage into the averaging bank.
	typedef struct packed {
		logic                load;
		logic [SENSOR_W-1:0] sensor;
		logic [CM_W-1:0]     cm;
	} erma_upd_t;

	// Averaging bank answer for the request that is being loaded.
	typedef struct packed {
		logic [CM_W-1:0] average;
		logic            near_first;
		logic            near_second;
	} erma_res_t;

endpackage

[rtl/erma_avg_bank.sv]
// ----------------------------------------------------------------------------
// erma_avg_bank
// Per-sensor distance rings, slot pointers and latest averages.
// ----------------------------------------------------------------------------
module erma_avg_bank
	import erma_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  erma_upd_t       upd,
	input  logic [CM_W-1:0] threshold,
	output erma_res_t       res
);

	localparam int SECOND_IDX = (SENSORS > 1) ? 1 : 0;

	logic [CM_W-1:0]  ring_q   [SENSORS][TAPS];
	logic [TAP_W-1:0] ptr_q    [SENSORS];
	logic [CM_W-1:0]  latest_q [SENSORS];

	logic [SIDX_W-1:0] idx;
	logic              in_range;
	logic [TAP_W-1:0]  ptr;
	logic [TAP_W-1:0]  ptr_next;
	logic [CM_W-1:0]   new_row [TAPS];
	logic [SUM_W-1:0]  sum;
	logic [CM_W-1:0]   avg;
	logic [CM_W-1:0]   lat_first;
	logic [CM_W-1:0]   lat_second;

	assign idx      = upd.sensor[SIDX_W-1:0];
	assign in_range = (int'(upd.sensor) < SENSORS);
	assign ptr      = ptr_q[idx];
	assign ptr_next = (ptr == TAP_W'(TAPS - 1)) ? '0 : ptr + TAP_W'(1);

	// The new sample replaces the slot under the pointer before summing.
	always_comb begin
		sum = '0;
		for (int k = 0; k < TAPS; k++) begin
			new_row[k] = (TAP_W'(k) == ptr) ? upd.cm : ring_q[idx][k];
			sum        = sum + SUM_W'(new_row[k]);
		end
	end

	always_comb begin
		avg        = in_range ? CM_W'(sum / TAPS) : '0;
		lat_first  = (in_range && idx == SIDX_W'(0)) ? avg : latest_q[0];
		lat_second = (in_range && idx == SIDX_W'(SECOND_IDX)) ? avg : latest_q[SECOND_IDX];

		res.average     = avg;
		res.near_first  = (lat_first < threshold);
		res.near_second = (SENSORS > 1) ? (lat_second < threshold) : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SENSORS; s++) begin
				ptr_q[s]    <= '0;
				latest_q[s] <= '0;
				for (int k = 0; k < TAPS; k++) begin
					ring_q[s][k] <= '0;
				end
			end
		end else if (upd.load && in_range) begin
			for (int k = 0; k < TAPS; k++) begin
				ring_q[idx][k] <= new_row[k];
			end
			ptr_q[idx]    <= ptr_next;
			latest_q[idx] <= avg;
		end
	end

endmodule

[rtl/echo_range_moving_average_core.sv]
// ----------------------------------------------------------------------------
// echo_range_moving_average_core: four-sample range averaging per sensor
// Flow: a request is registered in stage one, then loaded into the output
// register. Throughput: one request per cycle through the two-stage
// convert/average path, as long as out_ready does not stall the output.
// Reset: arst_n clears all rings, pointers and averages and sets threshold 30.
// ----------------------------------------------------------------------------
`include "echo_range_moving_average_core_assert.svh"

module echo_range_moving_average_core
	import erma_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,

	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,

	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data,

	input  logic            cfg_we,
	input  logic [CM_W-1:0] cfg_data
);

	// Stage one converts the echo time to centimeters. Stage two reads the
	// sensor's ring, inserts the new distance, averages the slots, compares
	// against the threshold and loads the output register. State is written
	// only in stage two, so back-to-back requests for the same sensor see
	// each other's updates without any forwarding.

	logic [CM_W-1:0] threshold_q;

	logic                valid_s1;
	logic [SENSOR_W-1:0] sensor_s1;
	logic [CM_W-1:0]     cm_s1;

	logic      out_valid_q;
	out_item_t out_q;

	logic [PROD_W-1:0] prod;
	logic              out_load;
	erma_upd_t         upd;
	erma_res_t         res;

	// The output register takes a new result when it is empty or its current
	// result is being taken this cycle. Stage one accepts a request when it
	// is empty or drains into the output register, so a request can enter
	// while a finished result is still waiting.
	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || out_load;

	// Reciprocal multiply stands in for the divide by 58.
	assign prod = PROD_W'(in_data.echo_us) * PROD_W'(CM_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sensor_s1 <= in_data.sensor_index;
			cm_s1     <= CM_W'(prod >> CM_SHIFT);
		end
	end

	assign upd.load   = out_load;
	assign upd.sensor = sensor_s1;
	assign upd.cm     = cm_s1;

	erma_avg_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.threshold (threshold_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sensor_out  <= sensor_s1;
			out_q.average_cm  <= res.average;
			out_q.near_first  <= res.near_first;
			out_q.near_second <= res.near_second;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A request entering a full stage one must be matched by a drain.
	`ERMA_ASSERT_IMPL(a_s1_no_overrun, in_valid && in_ready && valid_s1, out_load)
	// An empty stage one always accepts.
	`ERMA_ASSERT_IMPL(a_s1_empty_ready, !valid_s1, in_ready)
	// The converted distance stays within the range of a 16-bit echo.
	`ERMA_ASSERT_IMPL(a_cm_range, valid_s1, int'(cm_s1) <= CM_MAX)
	// A loaded result is visible in the next cycle.
	`ERMA_ASSERT_NEXT(a_load_shows, out_load, out_valid_q)
	// An average never exceeds the largest distance a 16-bit echo can give.
	`ERMA_ASSERT_IMPL(a_avg_range, out_valid_q, int'(out_q.average_cm) <= CM_MAX)

endmodule
